### rtl/core/tdpc_pkg.sv
package tdpc_pkg;

  localparam int SIDE   = 7;
  localparam int DSIDE  = SIDE - 1;
  localparam int CODE_W = SIDE * SIDE;
  localparam int DATA_W = DSIDE * DSIDE;
  localparam int STAT_W = 3;

  typedef enum logic {
    REQ_ENCODE  = 1'b0,
    REQ_CORRECT = 1'b1
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CLEAN  = 3'd0,
    ST_DATA   = 3'd1,
    ST_ROW    = 3'd2,
    ST_COL    = 3'd3,
    ST_CORNER = 3'd4,
    ST_FAIL   = 3'd5
  } status_t;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [DSIDE-1:0]  syn_t;

  // data bits of a square, row-major
  function automatic data_t tdpc_data_of(code_t w);
    data_t d;
    for (int r = 0; r < DSIDE; r++) begin
      d[r*DSIDE +: DSIDE] = w[r*SIDE +: DSIDE];
    end
    return d;
  endfunction

  // one bit per row: data parity disagrees with the stored row parity
  function automatic syn_t tdpc_row_syn(code_t w);
    syn_t s;
    for (int r = 0; r < DSIDE; r++) begin
      s[r] = (^w[r*SIDE +: DSIDE]) ^ w[r*SIDE + DSIDE];
    end
    return s;
  endfunction

  function automatic syn_t tdpc_col_syn(code_t w);
    syn_t s;
    logic x;
    for (int c = 0; c < DSIDE; c++) begin
      x = w[DSIDE*SIDE + c];
      for (int r = 0; r < DSIDE; r++) begin
        x = x ^ w[r*SIDE + c];
      end
      s[c] = x;
    end
    return s;
  endfunction

  // corner is the and of the parity-column and parity-row weights
  function automatic logic tdpc_corner(code_t w);
    logic a;
    logic b;
    a = 1'b0;
    b = 1'b0;
    for (int i = 0; i < DSIDE; i++) begin
      a = a ^ w[i*SIDE + DSIDE];
      b = b ^ w[DSIDE*SIDE + i];
    end
    return a & b;
  endfunction

endpackage

### rtl/core/tdpc_if.sv
interface tdpc_in_if import tdpc_pkg::*; ();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  data_t     data_in;
  code_t     code_in;

  modport source (output valid, output req_type, output data_in, output code_in,
                  input ready);
  modport sink   (input valid, input req_type, input data_in, input code_in,
                  output ready);
endinterface

interface tdpc_out_if import tdpc_pkg::*; ();
  logic    valid;
  logic    ready;
  code_t   code_out;
  data_t   data_out;
  status_t status;

  modport source (output valid, output code_out, output data_out, output status,
                  input ready);
  modport sink   (input valid, input code_out, input data_out, input status,
                  output ready);
endinterface

### rtl/core/two_dim_parity_codec.sv
// Two-dimensional parity codec on a 7x7 bit square. An encode request turns
// 36 data bits into the square with row, column and corner parity; a correct
// request repairs any single-error case and reports what was fixed, or flags
// the word as uncorrectable and returns it unchanged. One request is taken
// every cycle while the result register is not stalled; each result passes
// through the input register, then the result register, before it is offered
// on the output. A stalled result register still lets one more request into
// the input register. No configuration.
module two_dim_parity_codec import tdpc_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  tdpc_in_if.sink     in_if,
  tdpc_out_if.source  out_if
);

  logic      s1_vld_r;
  req_type_t s1_req_r;
  data_t     s1_data_r;
  code_t     s1_code_r;

  logic      out_vld_r;
  code_t     out_code_r;
  data_t     out_data_r;
  status_t   out_stat_r;

  logic      out_load;
  logic      s1_load;

  code_t     enc_code;
  code_t     fix_code;
  status_t   fix_stat;
  code_t     res_code;
  status_t   res_stat;

  assign out_load    = s1_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || out_load;
  assign s1_load     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= 1'b1;
    end else if (out_load) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_req_r  <= in_if.req_type;
      s1_data_r <= in_if.data_in;
      s1_code_r <= in_if.code_in;
    end
  end

  tdpc_enc u_enc (
    .data (s1_data_r),
    .code (enc_code)
  );

  tdpc_corr u_corr (
    .code_in  (s1_code_r),
    .code_fix (fix_code),
    .status   (fix_stat)
  );

  always_comb begin
    unique case (s1_req_r)
      REQ_ENCODE: begin
        res_code = enc_code;
        res_stat = ST_CLEAN;
      end
      REQ_CORRECT: begin
        res_code = fix_code;
        res_stat = fix_stat;
      end
      default: begin
        res_code = fix_code;
        res_stat = fix_stat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= res_code;
      out_data_r <= tdpc_data_of(res_code);
      out_stat_r <= res_stat;
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.code_out = out_code_r;
  assign out_if.data_out = out_data_r;
  assign out_if.status   = out_stat_r;

`ifndef SYNTHESIS
  // any repaired or encoded square must be fully parity consistent
  a_clean_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_stat_r != ST_FAIL) |->
      (tdpc_row_syn(out_code_r) == '0) && (tdpc_col_syn(out_code_r) == '0) &&
      (out_code_r[CODE_W-1] == tdpc_corner(out_code_r)))
    else $error("result square not parity consistent");

  a_data_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_data_r == tdpc_data_of(out_code_r))
    else $error("data bits disagree with result square");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_load |=> s1_vld_r && $stable(s1_code_r) && $stable(s1_data_r))
    else $error("stalled request lost from input register");

  a_encode_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (s1_req_r == REQ_ENCODE) |=> out_stat_r == ST_CLEAN)
    else $error("encode request reported a repair");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_vld_r && !out_vld_r)
    else $error("valid state survived reset");
`endif

endmodule

### rtl/core/tdpc_enc.sv
module tdpc_enc import tdpc_pkg::*; (
  input  data_t data,
  output code_t code
);

  code_t w;

  always_comb begin
    w = '0;
    for (int r = 0; r < DSIDE; r++) begin
      w[r*SIDE +: DSIDE] = data[r*DSIDE +: DSIDE];
    end
    for (int i = 0; i < DSIDE; i++) begin
      w[i*SIDE + DSIDE] = ^data[i*DSIDE +: DSIDE];
    end
    // column parity: stored row is still zero, so the syndrome is the parity
    w[DSIDE*SIDE +: DSIDE] = tdpc_col_syn(w);
    w[CODE_W-1] = tdpc_corner(w);
  end

  assign code = w;

endmodule

### rtl/core/tdpc_corr.sv
module tdpc_corr import tdpc_pkg::*; (
  input  code_t   code_in,
  output code_t   code_fix,
  output status_t status
);

  syn_t  rs;
  syn_t  cs;
  logic  rs_multi;
  logic  cs_multi;
  logic  rs_any;
  logic  cs_any;
  code_t w;
  logic  corner;

  assign rs       = tdpc_row_syn(code_in);
  assign cs       = tdpc_col_syn(code_in);
  assign rs_any   = |rs;
  assign cs_any   = |cs;
  assign rs_multi = |(rs & (rs - syn_t'(1)));
  assign cs_multi = |(cs & (cs - syn_t'(1)));

  // single-error repair as a flip mask; corner recomputed afterwards
  always_comb begin
    w = code_in;
    for (int r = 0; r < DSIDE; r++) begin
      for (int c = 0; c < DSIDE; c++) begin
        w[r*SIDE + c] = code_in[r*SIDE + c] ^ (rs[r] & cs[c]);
      end
      w[r*SIDE + DSIDE] = code_in[r*SIDE + DSIDE] ^ (rs[r] & !cs_any);
      w[DSIDE*SIDE + r] = code_in[DSIDE*SIDE + r] ^ (cs[r] & !rs_any);
    end
    corner      = tdpc_corner(w);
    w[CODE_W-1] = corner;
  end

  always_comb begin
    code_fix = w;
    priority if (rs_multi || cs_multi) begin
      status   = ST_FAIL;
      code_fix = code_in;
    end else if (rs_any && cs_any) begin
      status = ST_DATA;
    end else if (rs_any) begin
      status = ST_ROW;
    end else if (cs_any) begin
      status = ST_COL;
    end else if (corner != code_in[CODE_W-1]) begin
      status = ST_CORNER;
    end else begin
      status = ST_CLEAN;
    end
  end

endmodule

### tb/tdpc_codec_checker.sv
`timescale 1ns / 1ps

module tdpc_codec_checker import tdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tdpc_in_if         in_mon,
  tdpc_out_if        out_mon,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output logic [5:0] status_seen
);

  typedef struct packed {
    code_t   code;
    data_t   data;
    status_t status;
  } square_t;

  localparam int CORNER_POS = DSIDE * SIDE + DSIDE;
  localparam int MAX_PRINTS = 50;

  square_t expected_q[$];
  square_t want;
  int      mismatches = 0;

  assign fail_count = mismatches;

  // and of the parity-column weight and the parity-row weight
  function automatic logic corner_bit(code_t w);
    logic col_w;
    logic row_w;
    col_w = 1'b0;
    row_w = 1'b0;
    for (int i = 0; i < DSIDE; i++) begin
      col_w ^= w[i*SIDE + DSIDE];
      row_w ^= w[DSIDE*SIDE + i];
    end
    return col_w & row_w;
  endfunction

  function automatic square_t predict_result(req_type_t kind, data_t d, code_t c);
    square_t res;
    code_t   w;
    logic    mis;
    int      nrow;
    int      ncol;
    int      er;
    int      ec;
    w = '0;
    nrow = 0;
    ncol = 0;
    er = 0;
    ec = 0;
    res.status = ST_CLEAN;
    if (kind == REQ_ENCODE) begin
      for (int r = 0; r < DSIDE; r++) begin
        for (int k = 0; k < DSIDE; k++) begin
          w[r*SIDE + k] = d[r*DSIDE + k];
          w[r*SIDE + DSIDE] ^= d[r*DSIDE + k];
          w[DSIDE*SIDE + k] ^= d[r*DSIDE + k];
        end
      end
      w[CORNER_POS] = corner_bit(w);
    end else begin
      w = c;
      for (int i = 0; i < DSIDE; i++) begin
        mis = w[i*SIDE + DSIDE];
        for (int k = 0; k < DSIDE; k++) mis ^= w[i*SIDE + k];
        if (mis) begin
          nrow++;
          er = i;
        end
        mis = w[DSIDE*SIDE + i];
        for (int k = 0; k < DSIDE; k++) mis ^= w[k*SIDE + i];
        if (mis) begin
          ncol++;
          ec = i;
        end
      end
      if (nrow > 1 || ncol > 1) begin
        res.status = ST_FAIL;
      end else if (nrow == 1 && ncol == 1) begin
        w[er*SIDE + ec] = ~w[er*SIDE + ec];
        w[CORNER_POS] = corner_bit(w);
        res.status = ST_DATA;
      end else if (nrow == 1) begin
        // stored parity disagrees, so rewriting it is a flip
        w[er*SIDE + DSIDE] = ~w[er*SIDE + DSIDE];
        w[CORNER_POS] = corner_bit(w);
        res.status = ST_ROW;
      end else if (ncol == 1) begin
        w[DSIDE*SIDE + ec] = ~w[DSIDE*SIDE + ec];
        w[CORNER_POS] = corner_bit(w);
        res.status = ST_COL;
      end else if (w[CORNER_POS] != corner_bit(w)) begin
        w[CORNER_POS] = ~w[CORNER_POS];
        res.status = ST_CORNER;
      end
    end
    res.code = w;
    for (int r = 0; r < DSIDE; r++) begin
      for (int k = 0; k < DSIDE; k++) res.data[r*DSIDE + k] = w[r*SIDE + k];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at result %0d, %s: got %h, want %h", checked, what, got, exp_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      pending <= 0;
      checked = 0;
      status_seen = '0;
    end else begin
      // compare before taking this edge's request: results lag their requests
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request", 64'(out_mon.code_out), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.code_out !== want.code) begin
            report_mismatch("code_out", 64'(out_mon.code_out), 64'(want.code));
          end
          if (out_mon.data_out !== want.data) begin
            report_mismatch("data_out", 64'(out_mon.data_out), 64'(want.data));
          end
          if (out_mon.status !== want.status) begin
            report_mismatch("status", 64'(out_mon.status), 64'(want.status));
          end
          if (want.status <= ST_FAIL) status_seen[want.status] = 1'b1;
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_result(in_mon.req_type, in_mon.data_in, in_mon.code_in));
      end
      pending <= expected_q.size();
    end
  end

endmodule

### tb/tb_two_dim_parity_codec.sv
`timescale 1ns / 1ps

module tb_two_dim_parity_codec;
  import tdpc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 60;
  localparam int CORNER_POS   = DSIDE * SIDE + DSIDE;

  typedef enum int {
    RX_FLOW,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic       clk;
  logic       rst_n;
  bit         in_valid_drv;
  bit         hold_out;
  int         n_encode;
  int         n_correct;
  int         cycle_cnt = 0;
  int         fail_count;
  int         pending;
  int         checked;
  logic [5:0] status_seen;

  tdpc_in_if  in_bus ();
  tdpc_out_if out_bus ();

  two_dim_parity_codec u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  tdpc_codec_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .status_seen (status_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // clean square for stimulus; corner is the parity of all data bits
  function automatic code_t encode_square(data_t d);
    code_t w;
    w = '0;
    for (int r = 0; r < DSIDE; r++) begin
      w[r*SIDE +: DSIDE] = d[r*DSIDE +: DSIDE];
      w[r*SIDE + DSIDE] = ^d[r*DSIDE +: DSIDE];
      w[DSIDE*SIDE +: DSIDE] ^= d[r*DSIDE +: DSIDE];
    end
    w[CORNER_POS] = ^d;
    return w;
  endfunction

  function automatic code_t flip_bit(code_t c, int pos);
    code_t m;
    m = '0;
    m[pos] = 1'b1;
    return c ^ m;
  endfunction

  task automatic offer(req_type_t kind, data_t d, code_t c);
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.data_in  <= d;
    in_bus.code_in  <= c;
    in_valid_drv = 1'b1;
    if (kind == REQ_ENCODE) n_encode++;
    else n_correct++;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic idle_in();
    if (in_valid_drv) begin
      in_bus.valid <= 1'b0;
      in_valid_drv = 1'b0;
    end
  endtask

  task automatic drain();
    idle_in();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic make_item(output req_type_t kind, output data_t d, output code_t c);
    logic [63:0] r1;
    logic [63:0] r2;
    int          pick;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    d = r1[DATA_W-1:0];
    c = r2[CODE_W-1:0];
    if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 1) ? '1 : '0;
    pick = $urandom_range(0, 99);
    kind = (pick < 25) ? REQ_ENCODE : REQ_CORRECT;
    if (pick >= 25 && pick < 91) c = encode_square(d);
    if (pick >= 37 && pick < 57) begin
      c = flip_bit(c, $urandom_range(0, DSIDE-1) * SIDE + $urandom_range(0, DSIDE-1));
    end else if (pick >= 57 && pick < 65) begin
      c = flip_bit(c, $urandom_range(0, DSIDE-1) * SIDE + DSIDE);
    end else if (pick >= 65 && pick < 73) begin
      c = flip_bit(c, DSIDE*SIDE + $urandom_range(0, DSIDE-1));
    end else if (pick >= 73 && pick < 81) begin
      c = flip_bit(c, CORNER_POS);
    end else if (pick >= 81 && pick < 91) begin
      // burst of errors anywhere in the square
      repeat ($urandom_range(2, 4)) c = flip_bit(c, $urandom_range(0, CODE_W-1));
    end
  endtask

  task automatic random_phase(int count, bit gapless);
    req_type_t kind;
    data_t     d;
    code_t     c;
    int        burst;
    int        gap;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      make_item(kind, d, c);
      offer(kind, d, c);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap = gapless ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          idle_in();
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // result side stall pattern
  initial begin
    rx_mode_t mode;
    int       left;
    out_bus.ready <= 1'b0;
    mode = RX_FLOW;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(10, 120);
        end
        left--;
        case (mode)
          RX_FLOW:   out_bus.ready <= 1'b1;
          RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   out_bus.ready <= (left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    code_t cw;
    code_t cw_odd;
    n_encode = 0;
    n_correct = 0;
    in_valid_drv = 1'b0;
    hold_out = 1'b0;
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= REQ_ENCODE;
    in_bus.data_in  <= '0;
    in_bus.code_in  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: data extremes, then each repair case
    offer(REQ_ENCODE, '0, '1);
    offer(REQ_ENCODE, '1, '0);
    offer(REQ_ENCODE, 36'hAAAAAAAAA, '0);
    offer(REQ_ENCODE, 36'h555555555, '0);
    offer(REQ_ENCODE, 36'h000000001, '0);
    offer(REQ_ENCODE, 36'h800000000, '0);
    cw = encode_square(36'h123456789);
    cw_odd = encode_square(36'h000000001);
    offer(REQ_CORRECT, '1, cw);
    offer(REQ_CORRECT, '0, '0);
    offer(REQ_CORRECT, '0, '1);
    offer(REQ_CORRECT, '0, flip_bit(cw, 0));
    offer(REQ_CORRECT, '0, flip_bit(cw, (DSIDE-1)*SIDE + DSIDE-1));
    offer(REQ_CORRECT, '0, flip_bit(cw, DSIDE));
    offer(REQ_CORRECT, '0, flip_bit(cw, (DSIDE-1)*SIDE + DSIDE));
    offer(REQ_CORRECT, '0, flip_bit(cw, DSIDE*SIDE));
    offer(REQ_CORRECT, '0, flip_bit(cw, DSIDE*SIDE + DSIDE-1));
    offer(REQ_CORRECT, '0, flip_bit(cw, CORNER_POS));
    offer(REQ_CORRECT, '0, flip_bit(cw_odd, CORNER_POS));
    // two data errors on distinct rows and columns, same row, same column
    offer(REQ_CORRECT, '0, flip_bit(flip_bit(cw, 0), SIDE + 1));
    offer(REQ_CORRECT, '0, flip_bit(flip_bit(cw, 0), 1));
    offer(REQ_CORRECT, '0, flip_bit(flip_bit(cw, 0), SIDE));
    // one row parity and one column parity error look like a data error
    offer(REQ_CORRECT, '0, flip_bit(flip_bit(cw, DSIDE), DSIDE*SIDE));
    drain();

    random_phase(600, 1'b0);
    // result side holds off while requests keep coming
    hold_out = 1'b1;
    random_phase(12, 1'b1);
    drain();
    random_phase(600, 1'b0);
    drain();
    random_phase(240, 1'b1);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d encode and %0d correct requests, %0d results compared, %0d cycles",
             n_encode, n_correct, checked, cycle_cnt);
    $display("status codes returned (uncorrectable..clean, msb first): %b, with long stall",
             status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
